FILE: sv/hcb_pkg.sv
package hcb_pkg;

	localparam int MAX_SYMBOLS_DEF = 32;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam int IN_WEIGHT_W = 16;
	localparam int SYM_W       = 5;
	localparam int CODE_W      = 31;
	localparam int LEN_W       = 5;

	typedef struct packed {
		logic [IN_WEIGHT_W-1:0] weight;
		logic                   final_item;
	} in_t;

	typedef struct packed {
		logic [SYM_W-1:0]  symbol_index;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
		logic              last_code;
		logic              overflow;
	} out_t;

endpackage

FILE: sv/huffman_code_builder.sv
// Huffman code builder, two-queue construction.
// Input channel: an item (weight, final_item) is taken on a rising edge with
// start high and busy low. Weights are meant to come in ascending order. Up to
// MAX_SYMBOLS items are stored; further ones are dropped and flagged in the
// overflow field of every result of that run.
// The item with final_item set starts construction; busy stays high until the
// last code has been given out.
// Result channel: result_valid is high for one cycle per leaf, in depth-first
// order (0 branch first), with result.last_code on the final one. The receiver
// cannot stall; results must be taken when shown.
// Non-final items are taken back to back while idle. After the final item, each
// merge passes through S_RDA, S_PKA, S_RDB and S_PKB (two reads and compares on
// the two-port node table), and the walk takes S_WPOP, S_WNODE and S_WEXP per
// leaf and adds S_WPUSH per inner node on the stack memory.
// A single symbol gives one code of length 0, set up in S_BUILD.
// Reset clears the state, counters, queue heads and stack pointer; the node table and stack need no clearing.
module huffman_code_builder #(
	parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
	parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  hcb_pkg::in_t  item,
	output logic          result_valid,
	output hcb_pkg::out_t result
);

	localparam int SLOTS = 2 * MAX_SYMBOLS;
	localparam int IDXW  = (SLOTS > 2) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(MAX_SYMBOLS + 1);
	localparam int NW    = WEIGHT_BITS + IDXW;
	localparam int CODEW = hcb_pkg::CODE_W;

	typedef struct packed {
		logic [NW-1:0]   weight;
		logic [IDXW-1:0] left;
		logic [IDXW-1:0] right;
	} node_t;

	typedef struct packed {
		logic [IDXW-1:0]  node;
		logic [IDXW-1:0]  depth;
		logic [CODEW-1:0] path;
	} stk_t;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_BUILD = 11'b00000000010,
		S_RDA   = 11'b00000000100,
		S_PKA   = 11'b00000001000,
		S_RDB   = 11'b00000010000,
		S_PKB   = 11'b00000100000,
		S_WINIT = 11'b00001000000,
		S_WPOP  = 11'b00010000000,
		S_WNODE = 11'b00100000000,
		S_WEXP  = 11'b01000000000,
		S_WPUSH = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [CW-1:0]   leaf_count_q;
	logic [CW-1:0]   count_q;
	logic            dropped_q;
	logic [IDXW-1:0] leaf_head_q, merged_head_q, merged_tail_q;
	logic [IDXW:0]   sp_q;
	logic [IDXW-1:0] a_idx_q;
	logic [NW-1:0]   a_w_q;
	stk_t            cur_q;
	logic [IDXW-1:0] left_q;
	logic            result_valid_q;
	hcb_pkg::out_t   result_q;

	// node table
	logic            nd_we;
	logic [IDXW-1:0] nd_waddr, nd_ra, nd_rb;
	node_t           nd_wdata, nd_rda, nd_rdb;

	hcb_node_mem #(
		.DEPTH(SLOTS),
		.WIDTH($bits(node_t)),
		.AW   (IDXW)
	) u_node_mem (
		.clk    (clk),
		.we     (nd_we),
		.waddr  (nd_waddr),
		.wdata  (nd_wdata),
		.raddr_a(nd_ra),
		.raddr_b(nd_rb),
		.rdata_a(nd_rda),
		.rdata_b(nd_rdb)
	);

	// walk stack
	stk_t            stk [SLOTS];
	stk_t            stk_rd;
	logic            stk_we;
	logic [IDXW-1:0] stk_waddr, stk_raddr;
	stk_t            stk_wdata;

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk[stk_waddr] <= stk_wdata;
		end
		stk_rd <= stk[stk_raddr];
	end

	logic [IDXW-1:0] n_x;
	logic            leaf_av, mrg_av, take_m, loop_done, is_leaf, is_last;
	logic [IDXW-1:0] pick_idx;
	logic [NW-1:0]   pick_w;
	logic [31:0]     w32;
	logic [NW-1:0]   w_in;
	logic [IDXW:0]   sp_m1;

	assign busy = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result = result_q;

	assign n_x       = IDXW'(leaf_count_q);
	assign leaf_av   = leaf_head_q < n_x;
	assign mrg_av    = merged_head_q != merged_tail_q;
	assign take_m    = !leaf_av || (mrg_av && (nd_rdb.weight < nd_rda.weight));
	assign pick_idx  = take_m ? merged_head_q : leaf_head_q;
	assign pick_w    = take_m ? nd_rdb.weight : nd_rda.weight;
	assign loop_done = !leaf_av && ((merged_tail_q - merged_head_q) == IDXW'(1));
	assign is_leaf   = cur_q.node < n_x;
	assign is_last   = count_q == CW'(leaf_count_q - CW'(1));
	assign w32       = 32'(item.weight);
	assign w_in      = NW'(w32[WEIGHT_BITS-1:0]);
	assign sp_m1     = sp_q - (IDXW+1)'(1);

	always_comb begin
		nd_we     = 1'b0;
		nd_waddr  = merged_tail_q;
		nd_wdata  = '{weight: a_w_q + pick_w, left: a_idx_q, right: pick_idx};
		nd_ra     = cur_q.node;
		nd_rb     = merged_head_q;
		stk_we    = 1'b0;
		stk_waddr = sp_q[IDXW-1:0];
		stk_wdata = '{node: nd_rda.right, depth: cur_q.depth + IDXW'(1),
			path: {cur_q.path[CODEW-2:0], 1'b1}};
		stk_raddr = sp_m1[IDXW-1:0];
		unique case (state_q)
			S_IDLE: begin
				nd_we    = start && (leaf_count_q < CW'(MAX_SYMBOLS));
				nd_waddr = IDXW'(leaf_count_q);
				nd_wdata = '{weight: w_in, left: '0, right: '0};
			end
			S_RDA, S_RDB: begin
				nd_ra = leaf_head_q;
			end
			S_PKB: begin
				nd_we = 1'b1;
			end
			S_WINIT: begin
				stk_we    = 1'b1;
				stk_waddr = '0;
				stk_wdata = '{node: merged_head_q, depth: '0, path: '0};
			end
			S_WNODE: begin
				nd_ra = stk_rd.node;
			end
			S_WEXP: begin
				stk_we = !is_leaf;
			end
			S_WPUSH: begin
				stk_we    = 1'b1;
				stk_waddr = IDXW'(sp_q + (IDXW+1)'(1));
				stk_wdata = '{node: left_q, depth: cur_q.depth + IDXW'(1),
					path: {cur_q.path[CODEW-2:0], 1'b0}};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			leaf_count_q   <= '0;
			count_q        <= '0;
			dropped_q      <= 1'b0;
			leaf_head_q    <= '0;
			merged_head_q  <= '0;
			merged_tail_q  <= '0;
			sp_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (leaf_count_q < CW'(MAX_SYMBOLS)) begin
							leaf_count_q <= leaf_count_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (item.final_item) begin
							state_q <= S_BUILD;
						end
					end
				end
				S_BUILD: begin
					if (leaf_count_q <= CW'(1)) begin
						result_valid_q <= 1'b1;
						result_q <= '{symbol_index: '0, code_bits: '0, code_length: '0,
							last_code: 1'b1, overflow: dropped_q};
						leaf_count_q <= '0;
						dropped_q    <= 1'b0;
						state_q      <= S_IDLE;
					end else begin
						leaf_head_q   <= '0;
						merged_head_q <= n_x;
						merged_tail_q <= n_x;
						count_q       <= '0;
						state_q       <= S_RDA;
					end
				end
				S_RDA: begin
					state_q <= loop_done ? S_WINIT : S_PKA;
				end
				S_PKA: begin
					a_idx_q <= pick_idx;
					a_w_q   <= pick_w;
					if (take_m) begin
						merged_head_q <= merged_head_q + IDXW'(1);
					end else begin
						leaf_head_q <= leaf_head_q + IDXW'(1);
					end
					state_q <= S_RDB;
				end
				S_RDB: begin
					state_q <= S_PKB;
				end
				S_PKB: begin
					if (take_m) begin
						merged_head_q <= merged_head_q + IDXW'(1);
					end else begin
						leaf_head_q <= leaf_head_q + IDXW'(1);
					end
					merged_tail_q <= merged_tail_q + IDXW'(1);
					state_q       <= S_RDA;
				end
				S_WINIT: begin
					sp_q    <= (IDXW+1)'(1);
					state_q <= S_WPOP;
				end
				S_WPOP: begin
					sp_q    <= sp_m1;
					state_q <= S_WNODE;
				end
				S_WNODE: begin
					cur_q   <= stk_rd;
					state_q <= S_WEXP;
				end
				S_WEXP: begin
					if (is_leaf) begin
						result_valid_q <= 1'b1;
						result_q <= '{symbol_index: hcb_pkg::SYM_W'(cur_q.node),
							code_bits: cur_q.path,
							code_length: hcb_pkg::LEN_W'(cur_q.depth),
							last_code: is_last, overflow: dropped_q};
						count_q <= count_q + CW'(1);
						if (is_last) begin
							leaf_count_q  <= '0;
							dropped_q     <= 1'b0;
							leaf_head_q   <= '0;
							merged_head_q <= '0;
							merged_tail_q <= '0;
							state_q       <= S_IDLE;
						end else begin
							state_q <= S_WPOP;
						end
					end else begin
						left_q  <= nd_rda.left;
						state_q <= S_WPUSH;
					end
				end
				S_WPUSH: begin
					sp_q    <= sp_q + (IDXW+1)'(2);
					state_q <= S_WPOP;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/hcb_node_mem.sv
module hcb_node_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 34,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
